@@ rtl/sle_pkg.sv @@
// Shared types and constants for the sequential list engine.
`default_nettype none

package sle_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned GroupSize   = 8;
  localparam int unsigned ModeW       = 2;
  localparam int unsigned PosW        = 7;
  localparam int unsigned ValW        = 32;
  localparam int unsigned LenW        = 7;

  typedef enum logic [ModeW-1:0] {
    ModeInsert = 2'd0,
    ModeDelPos = 2'd1,
    ModeDelVal = 2'd2,
    ModeFind   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StMatch = 4'b0010,
    StScan  = 4'b0100,
    StApply = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
    logic live;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/sle_cell.sv @@
// One list slot: holds an entry, shifts with its neighbors, flags a key match.
`default_nettype none

module sle_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire sle_pkg::cell_ctrl_t      ctrl_i,
  input  wire logic [sle_pkg::ValW-1:0] key_i,
  input  wire logic [sle_pkg::ValW-1:0] left_i,
  input  wire logic [sle_pkg::ValW-1:0] right_i,
  output logic      [sle_pkg::ValW-1:0] data_o,
  output logic                          match_o
);

  logic [sle_pkg::ValW-1:0] data_q, data_d;
  logic                     match_q, match_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = key_i;
    end else if (ctrl_i.take_left) begin
      data_d = left_i;
    end else if (ctrl_i.take_right) begin
      data_d = right_i;
    end
    match_d = ctrl_i.live && (data_q == key_i);
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

@@ rtl/sequential_list_engine.sv @@
// Top level of the sequential list engine: request sequencer over a row of list cells.
//
//   channel  | ports                                            | handshake
//   request  | mode_i, position_i, value_i                      | start & !busy
//   result   | status_o, found_o, hit_position_o, probes_o,     | done_o, one cycle
//            | length_o                                         |
//
// Insert and delete at position go from idle straight to the apply state; done is registered after it.
// Delete by value and find pass through the match, scan and apply states; the scan walks groups
// of 8 cells (at most ceil(Capacity/8)) over the registered match flags.
// Reset clears the entry count; entry contents are not cleared.
// busy is high from acceptance until the done cycle; the receiver cannot stall.
`default_nettype none

module sequential_list_engine #(
  parameter int unsigned Capacity = sle_pkg::DefCapacity
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [sle_pkg::ModeW-1:0] mode_i,
  input  wire logic [sle_pkg::PosW-1:0]  position_i,
  input  wire logic [sle_pkg::ValW-1:0]  value_i,
  output logic                           done_o,
  output logic                           status_o,
  output logic                           found_o,
  output logic [sle_pkg::PosW-1:0]       hit_position_o,
  output logic [sle_pkg::LenW-1:0]       probes_o,
  output logic [sle_pkg::LenW-1:0]       length_o
);

  localparam int unsigned GSize   = sle_pkg::GroupSize;
  localparam int unsigned Groups  = (Capacity + GSize - 1) / GSize;
  localparam int unsigned GrpW    = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int unsigned BitW    = $clog2(GSize);
  localparam int unsigned HitW    = GrpW + BitW;
  localparam int unsigned CntW    = $clog2(Capacity + 1);
  localparam int unsigned CmpBase = (CntW > sle_pkg::PosW) ? CntW : sle_pkg::PosW;
  localparam int unsigned CmpW    = ((HitW > CmpBase) ? HitW : CmpBase) + 1;
  localparam int unsigned VecW    = Groups * GSize;

  sle_pkg::state_e              state_q, state_d;
  sle_pkg::mode_e               mode_q, mode_d;
  logic [sle_pkg::PosW-1:0]     pos_q, pos_d;
  logic [sle_pkg::ValW-1:0]     val_q, val_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [GrpW-1:0]              grp_q, grp_d;
  logic [HitW-1:0]              hit_idx_q, hit_idx_d;
  logic                         hit_q, hit_d;

  logic                         done_q, done_d;
  logic                         status_q, status_d;
  logic                         found_q, found_d;
  logic [sle_pkg::PosW-1:0]     hitpos_q, hitpos_d;
  logic [sle_pkg::LenW-1:0]     probes_q, probes_d;

  logic [sle_pkg::ValW-1:0]     data_w [Capacity];
  logic [Capacity-1:0]          match_w;
  logic [VecW-1:0]              match_vec;
  logic [GSize-1:0]             grp_bits;
  logic                         grp_any;
  logic [BitW-1:0]              first_bit, last_bit;

  logic                         ins_ok, del_ok;
  logic [CmpW-1:0]              tgt;
  logic [CmpW-1:0]              cnt_x, pos_x, hit_x;
  sle_pkg::cell_ctrl_t          ctrl_w [Capacity];

  assign cnt_x = CmpW'(cnt_q);
  assign pos_x = CmpW'(pos_q);
  assign hit_x = CmpW'(hit_idx_q);

  always_comb begin
    match_vec = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      match_vec[i] = match_w[i];
    end
  end

  assign grp_bits = match_vec[{grp_q, BitW'(0)} +: GSize];
  assign grp_any  = |grp_bits;

  always_comb begin
    first_bit = '0;
    last_bit  = '0;
    for (int i = GSize - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        first_bit = BitW'(i);
      end
    end
    for (int i = 0; i < GSize; i++) begin
      if (grp_bits[i]) begin
        last_bit = BitW'(i);
      end
    end
  end

  // Operation legality and target slot, only acted on in the apply state.
  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    tgt    = pos_x - CmpW'(1);
    if (state_q == sle_pkg::StApply) begin
      unique case (mode_q)
        sle_pkg::ModeInsert: begin
          ins_ok = (pos_x != '0) && (pos_x <= cnt_x + CmpW'(1)) &&
                   (cnt_x < CmpW'(Capacity));
        end
        sle_pkg::ModeDelPos: begin
          del_ok = (pos_x != '0) && (pos_x <= cnt_x);
        end
        sle_pkg::ModeDelVal: begin
          del_ok = hit_q;
          tgt    = hit_x;
        end
        sle_pkg::ModeFind: begin
          del_ok = 1'b0;
        end
        default: begin
          del_ok = 1'b0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [sle_pkg::ValW-1:0] left_w, right_w;

    if (i > 0) begin : g_left
      assign left_w = data_w[i-1];
    end else begin : g_left0
      assign left_w = '0;
    end

    if (i < Capacity - 1) begin : g_right
      assign right_w = data_w[i+1];
    end else begin : g_right_end
      assign right_w = '0;
    end

    assign ctrl_w[i].load       = ins_ok && (CmpW'(i) == tgt);
    assign ctrl_w[i].take_left  = ins_ok && (CmpW'(i) > tgt);
    assign ctrl_w[i].take_right = del_ok && (CmpW'(i) >= tgt);
    assign ctrl_w[i].live       = CmpW'(i) < cnt_x;

    sle_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_w[i]),
      .key_i   (val_q),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data_w[i]),
      .match_o (match_w[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    pos_d     = pos_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    grp_d     = grp_q;
    hit_idx_d = hit_idx_q;
    hit_d     = hit_q;
    done_d    = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    hitpos_d  = hitpos_q;
    probes_d  = probes_q;

    unique case (state_q)
      sle_pkg::StIdle: begin
        if (start) begin
          mode_d = sle_pkg::mode_e'(mode_i);
          pos_d  = position_i;
          val_d  = value_i;
          hit_d  = 1'b0;
          if (mode_i == sle_pkg::ModeInsert || mode_i == sle_pkg::ModeDelPos) begin
            state_d = sle_pkg::StApply;
          end else begin
            state_d = sle_pkg::StMatch;
          end
        end
      end
      sle_pkg::StMatch: begin
        grp_d   = (mode_q == sle_pkg::ModeDelVal) ? '0 : GrpW'(Groups - 1);
        state_d = sle_pkg::StScan;
      end
      sle_pkg::StScan: begin
        if (mode_q == sle_pkg::ModeDelVal) begin
          if (grp_any) begin
            hit_d     = 1'b1;
            hit_idx_d = {grp_q, first_bit};
            state_d   = sle_pkg::StApply;
          end else if (grp_q == GrpW'(Groups - 1)) begin
            state_d = sle_pkg::StApply;
          end else begin
            grp_d = grp_q + GrpW'(1);
          end
        end else begin
          if (grp_any) begin
            hit_d     = 1'b1;
            hit_idx_d = {grp_q, last_bit};
            state_d   = sle_pkg::StApply;
          end else if (grp_q == '0) begin
            state_d = sle_pkg::StApply;
          end else begin
            grp_d = grp_q - GrpW'(1);
          end
        end
      end
      sle_pkg::StApply: begin
        done_d   = 1'b1;
        status_d = 1'b0;
        found_d  = 1'b0;
        hitpos_d = '0;
        probes_d = '0;
        unique case (mode_q) inside
          sle_pkg::ModeInsert: begin
            status_d = !ins_ok;
            if (ins_ok) begin
              cnt_d = cnt_q + CntW'(1);
            end
          end
          sle_pkg::ModeDelPos, sle_pkg::ModeDelVal: begin
            status_d = !del_ok;
            if (del_ok) begin
              cnt_d = cnt_q - CntW'(1);
            end
          end
          sle_pkg::ModeFind: begin
            found_d = hit_q;
            if (hit_q) begin
              hitpos_d = sle_pkg::PosW'(hit_x + CmpW'(1));
              probes_d = sle_pkg::LenW'(cnt_x - hit_x);
            end else begin
              probes_d = sle_pkg::LenW'(cnt_x + CmpW'(1));
            end
          end
          default: begin
            status_d = 1'b0;
          end
        endcase
        state_d = sle_pkg::StIdle;
      end
      default: begin
        state_d = sle_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sle_pkg::StIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    grp_q     <= grp_d;
    hit_idx_q <= hit_idx_d;
    status_q  <= status_d;
    found_q   <= found_d;
    hitpos_q  <= hitpos_d;
    probes_q  <= probes_d;
  end

  assign busy           = (state_q != sle_pkg::StIdle);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign hit_position_o = hitpos_q;
  assign probes_o       = probes_q;
  assign length_o       = sle_pkg::LenW'(cnt_q);

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for sequential_list_engine: list model with directed and random requests.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ListCap    = sle_pkg::DefCapacity;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic                     status;
    logic                     found;
    logic [sle_pkg::PosW-1:0] hit_position;
    logic [sle_pkg::LenW-1:0] probes;
    logic [sle_pkg::LenW-1:0] length;
  } list_result_t;

  logic                      clk_i;
  logic                      rst_ni     = 1'b0;
  logic                      start      = 1'b0;
  logic                      busy;
  logic [sle_pkg::ModeW-1:0] mode_i     = '0;
  logic [sle_pkg::PosW-1:0]  position_i = '0;
  logic [sle_pkg::ValW-1:0]  value_i    = '0;
  logic                      done_o;
  logic                      status_o;
  logic                      found_o;
  logic [sle_pkg::PosW-1:0]  hit_position_o;
  logic [sle_pkg::LenW-1:0]  probes_o;
  logic [sle_pkg::LenW-1:0]  length_o;

  logic [sle_pkg::ValW-1:0] list_q[$];
  list_result_t             pending_results[$];
  int unsigned              error_count = 0;
  int unsigned              cycle_count = 0;
  int unsigned              burst_left  = 8;

  sequential_list_engine #(
    .Capacity(ListCap)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_o       (found_o),
    .hit_position_o(hit_position_o),
    .probes_o      (probes_o),
    .length_o      (length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("sequential_list_engine test failed");
      $finish;
    end
  end

  function automatic list_result_t apply_list_request(sle_pkg::mode_e m,
                                                      logic [sle_pkg::PosW-1:0] p,
                                                      logic [sle_pkg::ValW-1:0] v);
    list_result_t r;
    int unsigned  len;
    int unsigned  n;
    int           idx;
    r   = '0;
    len = list_q.size();
    idx = -1;
    n   = 0;
    case (m)
      sle_pkg::ModeInsert: begin
        if (p < 1 || p > len + 1 || len >= ListCap) r.status = 1'b1;
        else list_q.insert(int'(p) - 1, v);
      end
      sle_pkg::ModeDelPos: begin
        if (p < 1 || p > len) r.status = 1'b1;
        else list_q.delete(int'(p) - 1);
      end
      sle_pkg::ModeDelVal: begin
        for (int i = 0; i < int'(len); i++) begin
          if (idx < 0 && list_q[i] == v) idx = i;
        end
        if (idx < 0) r.status = 1'b1;
        else list_q.delete(idx);
      end
      default: begin
        for (int i = int'(len); i > 0; i--) begin
          if (!r.found) begin
            n++;
            if (list_q[i-1] == v) begin
              r.found        = 1'b1;
              r.hit_position = sle_pkg::PosW'(i);
            end
          end
        end
        r.probes = r.found ? sle_pkg::LenW'(n) : sle_pkg::LenW'(n + 1);
      end
    endcase
    r.length = sle_pkg::LenW'(list_q.size());
    return r;
  endfunction

  function automatic void queue_result(list_result_t r);
    pending_results = {pending_results, r};
  endfunction

  task automatic send_item(sle_pkg::mode_e m, logic [sle_pkg::PosW-1:0] p,
                           logic [sle_pkg::ValW-1:0] v);
    int unsigned gap;
    start      <= 1'b1;
    mode_i     <= m;
    position_i <= p;
    value_i    <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
    queue_result(apply_list_request(m, p, v));
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [sle_pkg::ValW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40 && list_q.size() != 0) return list_q[$urandom_range(0, list_q.size() - 1)];
    if (sel < 60) return sle_pkg::ValW'($urandom_range(0, 7));
    if (sel < 70) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [sle_pkg::PosW-1:0] pick_position(sle_pkg::mode_e m);
    int unsigned len;
    len = list_q.size();
    if ($urandom_range(0, 3) == 0) return sle_pkg::PosW'($urandom_range(0, 127));
    if (m == sle_pkg::ModeInsert) return sle_pkg::PosW'($urandom_range(1, len + 1));
    if (m == sle_pkg::ModeDelPos && len != 0) return sle_pkg::PosW'($urandom_range(1, len));
    return sle_pkg::PosW'($urandom_range(0, 127));
  endfunction

  function automatic sle_pkg::mode_e pick_mode(int unsigned phase);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    case (phase)
      0: begin
        if (sel < 60) return sle_pkg::ModeInsert;
        if (sel < 70) return sle_pkg::ModeDelPos;
        if (sel < 80) return sle_pkg::ModeDelVal;
        return sle_pkg::ModeFind;
      end
      1:       return sle_pkg::mode_e'($urandom_range(0, 3));
      default: begin
        if (sel < 15) return sle_pkg::ModeInsert;
        if (sel < 50) return sle_pkg::ModeDelPos;
        if (sel < 80) return sle_pkg::ModeDelVal;
        return sle_pkg::ModeFind;
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_checker
    list_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending, expected none actual length %0d",
                 $time, length_o);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("found", 32'(want.found), 32'(found_o));
        check_field("hit_position", 32'(want.hit_position), 32'(hit_position_o));
        check_field("probes", 32'(want.probes), 32'(probes_o));
        check_field("length", 32'(want.length), 32'(length_o));
      end
    end
  end

  task automatic test_empty_list();
    send_item(sle_pkg::ModeFind, 7'd0, 32'd5);
    send_item(sle_pkg::ModeDelPos, 7'd1, 32'd0);
    send_item(sle_pkg::ModeDelVal, 7'd0, 32'd0);
    send_item(sle_pkg::ModeInsert, 7'd0, 32'd1);
    send_item(sle_pkg::ModeInsert, 7'd2, 32'd1);
  endtask

  task automatic test_edge_values();
    send_item(sle_pkg::ModeInsert, 7'd1, 32'h8000_0000);
    send_item(sle_pkg::ModeInsert, 7'd2, 32'h7FFF_FFFF);
    send_item(sle_pkg::ModeInsert, 7'd1, 32'h0000_0000);
    send_item(sle_pkg::ModeInsert, 7'd2, 32'hFFFF_FFFF);
    send_item(sle_pkg::ModeInsert, 7'd5, 32'h7FFF_FFFF);
    send_item(sle_pkg::ModeFind, 7'd127, 32'h7FFF_FFFF);
    send_item(sle_pkg::ModeFind, 7'd0, 32'h1234_5678);
    send_item(sle_pkg::ModeFind, 7'd0, 32'h0000_0000);
    send_item(sle_pkg::ModeDelVal, 7'd127, 32'h7FFF_FFFF);
    send_item(sle_pkg::ModeDelPos, 7'd127, 32'h0);
    send_item(sle_pkg::ModeInsert, 7'd127, 32'h5555_AAAA);
    send_item(sle_pkg::ModeDelPos, 7'd1, 32'h0);
    send_item(sle_pkg::ModeDelPos, sle_pkg::PosW'(list_q.size()), 32'h0);
    send_item(sle_pkg::ModeFind, 7'd0, 32'h8000_0000);
    send_item(sle_pkg::ModeDelVal, 7'd0, 32'h1234_5678);
    send_item(sle_pkg::ModeInsert, sle_pkg::PosW'(list_q.size() + 1), 32'hAAAA_5555);
  endtask

  task automatic test_full_list();
    logic [sle_pkg::ValW-1:0] v;
    logic                     hit;
    while (list_q.size() < ListCap) begin
      send_item(sle_pkg::ModeInsert, sle_pkg::PosW'($urandom_range(1, list_q.size() + 1)),
                pick_value());
    end
    send_item(sle_pkg::ModeInsert, sle_pkg::PosW'(ListCap + 1), $urandom);
    send_item(sle_pkg::ModeInsert, 7'd1, $urandom);
    send_item(sle_pkg::ModeFind, 7'd0, list_q[0]);
    do begin
      v   = $urandom;
      hit = 1'b0;
      foreach (list_q[i]) if (list_q[i] == v) hit = 1'b1;
    end while (hit);
    send_item(sle_pkg::ModeFind, 7'd0, v);
    send_item(sle_pkg::ModeDelVal, 7'd0, list_q[ListCap-1]);
    while (list_q.size() != 0) begin
      if ($urandom_range(0, 1) == 0) begin
        send_item(sle_pkg::ModeDelPos, pick_position(sle_pkg::ModeDelPos), 32'h0);
      end else begin
        send_item(sle_pkg::ModeDelVal, 7'd0, pick_value());
      end
    end
    send_item(sle_pkg::ModeDelVal, 7'd0, $urandom);
  endtask

  task automatic test_random_mix();
    sle_pkg::mode_e m;
    for (int unsigned round = 0; round < 13; round++) begin
      for (int unsigned k = 0; k < 100; k++) begin
        m = pick_mode(round % 3);
        send_item(m, pick_position(m), pick_value());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edge_values();
    test_full_list();
    test_random_mix();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (error_count == 0) $display("sequential_list_engine test passed");
    else $display("sequential_list_engine test failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/sle_pkg.sv
rtl/sle_cell.sv
rtl/sequential_list_engine.sv
tb/tb_top.sv
